[hw/rtl/pcr_pkg.sv]
// Shared constants and types for the polyline equal-chord resampler.
package pcr_pkg;

    localparam int COORD_W        = 32;
    localparam int CHORD_W        = 31;
    localparam logic [CHORD_W-1:0] CHORD_RESET = 31'd65536;
    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 32;

    // Shared multiply-accumulate unit
    localparam int MUL_W   = 34;
    localparam int ACC_W   = 130;
    localparam int SHAMT_W = 7;

    // Sequencer step counter width and step counts
    localparam int STEP_W     = 7;
    localparam int SQRT_STEPS = 64;
    localparam int DIV_STEPS  = 99;

    typedef struct packed {
        logic               en;
        logic               clear;
        logic               sub;
        logic [SHAMT_W-1:0] shamt;
    } mac_cmd_t;

endpackage

[hw/rtl/pcr_if.sv]
// Channel interfaces: vertex input, point output and chord configuration.
interface pcr_vertex_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcr_pkg::COORD_W-1:0]  vertex_x;
    logic signed [pcr_pkg::COORD_W-1:0]  vertex_y;
    logic                                new_polyline;

    modport source (output valid, vertex_x, vertex_y, new_polyline, input ready);
    modport sink   (input valid, vertex_x, vertex_y, new_polyline, output ready);
endinterface

interface pcr_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcr_pkg::COORD_W-1:0]  point_x;
    logic signed [pcr_pkg::COORD_W-1:0]  point_y;
    logic                                run_last;
    logic                                run_overflow;

    modport source (output valid, point_x, point_y, run_last, run_overflow, input ready);
    modport sink   (input valid, point_x, point_y, run_last, run_overflow, output ready);
endinterface

interface pcr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pcr_pkg::CHORD_W-1:0]       chord_distance;

    modport source (output valid, chord_distance, input ready);
    modport sink   (input valid, chord_distance, output ready);
endinterface

[hw/rtl/pcr_mac.sv]
// Shared signed multiply-accumulate unit with shifted partial products.
module pcr_mac
(
    input  logic                                    clk,
    input  pcr_pkg::mac_cmd_t                       cmd,
    input  logic signed [pcr_pkg::MUL_W-1:0]        op_a,
    input  logic signed [pcr_pkg::MUL_W-1:0]        op_b,
    output logic signed [pcr_pkg::ACC_W-1:0]        acc
);

    logic signed [2*pcr_pkg::MUL_W-1:0] prod;
    logic signed [pcr_pkg::ACC_W-1:0]   prod_ext;
    logic signed [pcr_pkg::ACC_W-1:0]   shifted;
    logic signed [pcr_pkg::ACC_W-1:0]   base;
    logic signed [pcr_pkg::ACC_W-1:0]   acc_reg;
    logic signed [pcr_pkg::ACC_W-1:0]   acc_next;

    // Form the partial product and align it
    always_comb
    begin
        prod     = op_a * op_b;
        prod_ext = pcr_pkg::ACC_W'(prod);
        shifted  = prod_ext <<< cmd.shamt;
        base     = cmd.clear ? '0 : acc_reg;
        acc_next = cmd.sub ? (base - shifted) : (base + shifted);
    end

    // Accumulate when issued
    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

[hw/rtl/polyline_equal_chord_resampler.sv]
// Top level: equal-chord resampler of polyline vertices with an iterative datapath.
//
//  channel | dir | handshake     | payload
//  vtx     | in  | valid/ready   | vertex_x, vertex_y, new_polyline
//  pts     | out | valid/ready   | point_x, point_y, run_last, run_overflow
//  cfg     | in  | valid/ready   | chord_distance (always ready)
//
// A polyline start is accepted and emitted as a one-point run. Any other
// vertex is accepted, squares the chord and runs a reach check; each emitted
// point then adds the segment terms, the one-bit-a-cycle square root, a clamp,
// two rounds of multiply and divide, and the next reach check, all on one
// shared multiply-accumulate unit. A point on a zero-length segment skips the
// square root, clamp and divides.
// The vertex channel is ready only when the sequencer is idle; a finished
// point waits as the center until the next reach check loads it into the output
// register, stalling there while the previous point still sits unaccepted.
// Reset clears control state; the chord resets to 65536 (CHORD_RESET).
module polyline_equal_chord_resampler
#(
    parameter int MAX_POINTS_PER_VERTEX = pcr_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS            = pcr_pkg::DEF_COORD_BITS
)
(
    input  logic           clk,
    input  logic           rst_n,
    pcr_vertex_if.sink     vtx,
    pcr_point_if.source    pts,
    pcr_cfg_if.sink        cfg
);

    localparam int IN_BITS = (COORD_BITS < pcr_pkg::COORD_W) ? COORD_BITS : pcr_pkg::COORD_W;
    localparam int SX_SH   = pcr_pkg::COORD_W - IN_BITS;
    localparam int CNT_W   = $clog2(MAX_POINTS_PER_VERTEX + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_RSQ, S_CHK, S_CROSS, S_SQRT, S_NCL, S_NUM, S_DIV
    } state_t;

    state_t state_reg;

    logic signed [31:0] vx_reg, vy_reg, px_reg, py_reg, cx_reg, cy_reg, ptx_reg;
    logic               started_reg;
    logic [30:0]        chord_reg;
    logic [61:0]        rsq_reg;
    logic [65:0]        a_reg;
    logic signed [67:0] b_reg;
    logic [63:0]        cr_reg;
    logic               cr_big_reg;
    logic [127:0]       x_reg;
    logic [63:0]        root_reg;
    logic [65:0]        rem_reg;
    logic [65:0]        n_reg;
    logic [98:0]        num_reg;
    logic               axis_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [pcr_pkg::STEP_W-1:0] step_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_x_reg, out_y_reg;
    logic               out_last_reg, out_ovf_reg;

    logic signed [31:0] vx_in, vy_in;
    logic signed [32:0] ex, ey, dx, dy, fx, fy, d_sel;
    logic [32:0]        dmag_sel;
    logic [30:0]        r_eff;
    logic               out_free;
    logic               out_load;
    logic               beyond;
    logic               zero_seg;
    logic signed [pcr_pkg::ACC_W-1:0] acc;
    logic signed [pcr_pkg::ACC_W-1:0] acc_abs;
    logic [127:0]       disc;
    logic signed [69:0] n_full;
    logic [67:0]        cs_a, cs_b, cs_diff;
    logic               cs_ge;
    logic [33:0]        q_rnd;
    logic signed [31:0] base_sel, coord_new;

    pcr_pkg::mac_cmd_t                  mac_cmd;
    logic signed [pcr_pkg::MUL_W-1:0]   mac_a, mac_b;

    function automatic logic signed [pcr_pkg::MUL_W-1:0] sx34(input logic signed [32:0] v);
        return {v[32], v};
    endfunction

    function automatic logic signed [pcr_pkg::MUL_W-1:0] zx34(input logic [32:0] v);
        return {1'b0, v};
    endfunction

    // Take the low coordinate bits, sign-extended
    assign vx_in = $signed(vtx.vertex_x <<  SX_SH) >>> SX_SH;
    assign vy_in = $signed(vtx.vertex_y <<  SX_SH) >>> SX_SH;

    // Geometry differences
    always_comb
    begin
        ex       = {vx_reg[31], vx_reg} - {cx_reg[31], cx_reg};
        ey       = {vy_reg[31], vy_reg} - {cy_reg[31], cy_reg};
        dx       = {vx_reg[31], vx_reg} - {px_reg[31], px_reg};
        dy       = {vy_reg[31], vy_reg} - {py_reg[31], py_reg};
        fx       = {px_reg[31], px_reg} - {cx_reg[31], cx_reg};
        fy       = {py_reg[31], py_reg} - {cy_reg[31], cy_reg};
        d_sel    = axis_reg ? dy : dx;
        dmag_sel = d_sel[32] ? (33'd0 - d_sel) : d_sel;
        base_sel = axis_reg ? py_reg : px_reg;
        r_eff    = (chord_reg == '0) ? 31'd1 : chord_reg;
        zero_seg = (dx == '0) && (dy == '0);
        out_free = !out_valid_reg || pts.ready;
        out_load = out_free && ((state_reg == S_START) ||
                   ((state_reg == S_CHK) && (step_reg == 7'd2) && (count_reg != '0)));
    end

    // Accumulator views
    always_comb
    begin
        beyond  = acc > $signed(pcr_pkg::ACC_W'(rsq_reg));
        acc_abs = acc[pcr_pkg::ACC_W-1] ? -acc : acc;
        disc    = (cr_big_reg || acc[pcr_pkg::ACC_W-1]) ? '0 : acc[127:0];
        n_full  = $signed({6'b0, root_reg}) - {{2{b_reg[67]}}, b_reg};
    end

    // Shared compare-subtract for square root and division
    always_comb
    begin
        cs_a = '0;
        cs_b = '0;
        if (state_reg == S_SQRT)
        begin
            cs_a = {rem_reg, x_reg[127:126]};
            cs_b = {2'b0, root_reg, 2'b01};
        end
        else if (step_reg == pcr_pkg::STEP_W'(pcr_pkg::DIV_STEPS))
        begin
            cs_a = {1'b0, rem_reg, 1'b0};
            cs_b = {2'b0, a_reg};
        end
        else
        begin
            cs_a = {1'b0, rem_reg, num_reg[98]};
            cs_b = {2'b0, a_reg};
        end
        cs_ge     = cs_a >= cs_b;
        cs_diff   = cs_a - cs_b;
        q_rnd     = num_reg[33:0] + {33'd0, cs_ge};
        coord_new = d_sel[32] ? (base_sel - q_rnd[31:0]) : (base_sel + q_rnd[31:0]);
    end

    // Issue multiply-accumulate operations
    always_comb
    begin
        mac_cmd = '0;
        mac_a   = '0;
        mac_b   = '0;
        unique case (state_reg)
            S_RSQ:
            begin
                if (step_reg == '0)
                begin
                    mac_cmd = '{en: 1'b1, clear: 1'b1, sub: 1'b0, shamt: '0};
                    mac_a   = zx34({2'b0, r_eff});
                    mac_b   = zx34({2'b0, r_eff});
                end
            end
            S_CHK:
            begin
                if (step_reg == '0)
                begin
                    mac_cmd = '{en: 1'b1, clear: 1'b1, sub: 1'b0, shamt: '0};
                    mac_a   = sx34(ex);
                    mac_b   = sx34(ex);
                end
                else if (step_reg == 7'd1)
                begin
                    mac_cmd = '{en: 1'b1, clear: 1'b0, sub: 1'b0, shamt: '0};
                    mac_a   = sx34(ey);
                    mac_b   = sx34(ey);
                end
            end
            S_CROSS:
            begin
                case (step_reg)
                    7'd0:
                    begin
                        mac_cmd = '{en: !zero_seg, clear: 1'b1, sub: 1'b0, shamt: '0};
                        mac_a   = sx34(dx);
                        mac_b   = sx34(dx);
                    end
                    7'd1:
                    begin
                        mac_cmd = '{en: 1'b1, clear: 1'b0, sub: 1'b0, shamt: '0};
                        mac_a   = sx34(dy);
                        mac_b   = sx34(dy);
                    end
                    7'd2:
                    begin
                        mac_cmd = '{en: 1'b1, clear: 1'b1, sub: 1'b0, shamt: '0};
                        mac_a   = sx34(fx);
                        mac_b   = sx34(dx);
                    end
                    7'd3:
                    begin
                        mac_cmd = '{en: 1'b1, clear: 1'b0, sub: 1'b0, shamt: '0};
                        mac_a   = sx34(fy);
                        mac_b   = sx34(dy);
                    end
                    7'd4:
                    begin
                        mac_cmd = '{en: 1'b1, clear: 1'b1, sub: 1'b0, shamt: '0};
                        mac_a   = sx34(dx);
                        mac_b   = sx34(fy);
                    end
                    7'd5:
                    begin
                        mac_cmd = '{en: 1'b1, clear: 1'b0, sub: 1'b1, shamt: '0};
                        mac_a   = sx34(dy);
                        mac_b   = sx34(fx);
                    end
                    7'd6:
                    begin
                        mac_cmd = '{en: 1'b1, clear: 1'b1, sub: 1'b0, shamt: 7'd0};
                        mac_a   = zx34(a_reg[32:0]);
                        mac_b   = zx34({2'b0, rsq_reg[30:0]});
                    end
                    7'd7:
                    begin
                        mac_cmd = '{en: 1'b1, clear: 1'b0, sub: 1'b0, shamt: 7'd31};
                        mac_a   = zx34(a_reg[32:0]);
                        mac_b   = zx34({2'b0, rsq_reg[61:31]});
                    end
                    7'd8:
                    begin
                        mac_cmd = '{en: 1'b1, clear: 1'b0, sub: 1'b0, shamt: 7'd33};
                        mac_a   = zx34(a_reg[65:33]);
                        mac_b   = zx34({2'b0, rsq_reg[30:0]});
                    end
                    7'd9:
                    begin
                        mac_cmd = '{en: 1'b1, clear: 1'b0, sub: 1'b0, shamt: 7'd64};
                        mac_a   = zx34(a_reg[65:33]);
                        mac_b   = zx34({2'b0, rsq_reg[61:31]});
                    end
                    7'd10:
                    begin
                        mac_cmd = '{en: 1'b1, clear: 1'b0, sub: 1'b1, shamt: 7'd0};
                        mac_a   = zx34({1'b0, cr_reg[31:0]});
                        mac_b   = zx34({1'b0, cr_reg[31:0]});
                    end
                    7'd11:
                    begin
                        mac_cmd = '{en: 1'b1, clear: 1'b0, sub: 1'b1, shamt: 7'd32};
                        mac_a   = zx34({1'b0, cr_reg[31:0]});
                        mac_b   = zx34({1'b0, cr_reg[63:32]});
                    end
                    7'd12:
                    begin
                        mac_cmd = '{en: 1'b1, clear: 1'b0, sub: 1'b1, shamt: 7'd32};
                        mac_a   = zx34({1'b0, cr_reg[63:32]});
                        mac_b   = zx34({1'b0, cr_reg[31:0]});
                    end
                    7'd13:
                    begin
                        mac_cmd = '{en: 1'b1, clear: 1'b0, sub: 1'b1, shamt: 7'd64};
                        mac_a   = zx34({1'b0, cr_reg[63:32]});
                        mac_b   = zx34({1'b0, cr_reg[63:32]});
                    end
                    default:
                    begin
                        mac_cmd = '0;
                    end
                endcase
            end
            S_NUM:
            begin
                if (step_reg == '0)
                begin
                    mac_cmd = '{en: 1'b1, clear: 1'b1, sub: 1'b0, shamt: 7'd0};
                    mac_a   = zx34(n_reg[32:0]);
                    mac_b   = zx34(dmag_sel);
                end
                else if (step_reg == 7'd1)
                begin
                    mac_cmd = '{en: 1'b1, clear: 1'b0, sub: 1'b0, shamt: 7'd33};
                    mac_a   = zx34(n_reg[65:33]);
                    mac_b   = zx34(dmag_sel);
                end
            end
            S_IDLE, S_START, S_SQRT, S_NCL, S_DIV:
            begin
                mac_cmd = '0;
            end
            default:
            begin
                mac_cmd = '0;
            end
        endcase
    end

    pcr_mac u_mac
    (
        .clk  (clk),
        .cmd  (mac_cmd),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (acc)
    );

    // Handshakes
    assign vtx.ready        = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign pts.valid        = out_valid_reg;
    assign pts.point_x      = out_x_reg;
    assign pts.point_y      = out_y_reg;
    assign pts.run_last     = out_last_reg;
    assign pts.run_overflow = out_ovf_reg;

    // Control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            chord_reg     <= pcr_pkg::CHORD_RESET;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            step_reg      <= '0;
            axis_reg      <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
        end
        else
        begin
            // Drop a transaction the sink has taken unless a new one loads
            if (pts.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.valid)
            begin
                chord_reg <= cfg.chord_distance;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (vtx.valid)
                    begin
                        vx_reg    <= vx_in;
                        vy_reg    <= vy_in;
                        count_reg <= '0;
                        step_reg  <= '0;
                        if (vtx.new_polyline || !started_reg)
                        begin
                            started_reg <= 1'b1;
                            px_reg      <= vx_in;
                            py_reg      <= vy_in;
                            cx_reg      <= vx_in;
                            cy_reg      <= vy_in;
                            state_reg   <= S_START;
                        end
                        else
                        begin
                            state_reg <= S_RSQ;
                        end
                    end
                end
                S_START:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= vx_reg;
                        out_y_reg     <= vy_reg;
                        out_last_reg  <= 1'b1;
                        out_ovf_reg   <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                S_RSQ:
                begin
                    if (step_reg == '0)
                    begin
                        step_reg <= 7'd1;
                    end
                    else
                    begin
                        rsq_reg   <= acc[61:0];
                        step_reg  <= '0;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (step_reg != 7'd2)
                    begin
                        step_reg <= step_reg + 7'd1;
                    end
                    else if (count_reg == '0)
                    begin
                        // First check: no pending point
                        step_reg <= '0;
                        if (beyond)
                        begin
                            state_reg <= S_CROSS;
                        end
                        else
                        begin
                            px_reg    <= vx_reg;
                            py_reg    <= vy_reg;
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (out_free)
                    begin
                        // Release the pending point; it ends the run unless another point follows
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= cx_reg;
                        out_y_reg     <= cy_reg;
                        step_reg      <= '0;
                        if (beyond && (count_reg < CNT_W'(MAX_POINTS_PER_VERTEX)))
                        begin
                            out_last_reg <= 1'b0;
                            out_ovf_reg  <= 1'b0;
                            state_reg    <= S_CROSS;
                        end
                        else
                        begin
                            out_last_reg <= 1'b1;
                            out_ovf_reg  <= beyond;
                            px_reg       <= vx_reg;
                            py_reg       <= vy_reg;
                            state_reg    <= S_IDLE;
                        end
                    end
                end
                S_CROSS:
                begin
                    // Advance the step, restarting on the last one or a point segment
                    if ((step_reg == 7'd14) || ((step_reg == '0) && zero_seg))
                    begin
                        step_reg <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 7'd1;
                    end
                    case (step_reg)
                        7'd0:
                        begin
                            if (zero_seg)
                            begin
                                cx_reg    <= vx_reg;
                                cy_reg    <= vy_reg;
                                count_reg <= count_reg + CNT_W'(1);
                                state_reg <= S_CHK;
                            end
                        end
                        7'd2:
                        begin
                            a_reg <= acc[65:0];
                        end
                        7'd4:
                        begin
                            b_reg <= acc[67:0];
                        end
                        7'd6:
                        begin
                            cr_reg     <= acc_abs[63:0];
                            cr_big_reg <= |acc_abs[pcr_pkg::ACC_W-1:64];
                        end
                        7'd14:
                        begin
                            x_reg     <= disc;
                            root_reg  <= '0;
                            rem_reg   <= '0;
                            state_reg <= S_SQRT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SQRT:
                begin
                    // One root bit per cycle
                    rem_reg  <= cs_ge ? cs_diff[65:0] : cs_a[65:0];
                    root_reg <= {root_reg[62:0], cs_ge};
                    x_reg    <= {x_reg[125:0], 2'b00};
                    if (step_reg == pcr_pkg::STEP_W'(pcr_pkg::SQRT_STEPS - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= S_NCL;
                    end
                    else
                    begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                S_NCL:
                begin
                    // Clamp the parameter to the segment
                    if (n_full[69])
                    begin
                        n_reg <= '0;
                    end
                    else if (n_full > $signed({4'b0, a_reg}))
                    begin
                        n_reg <= a_reg;
                    end
                    else
                    begin
                        n_reg <= n_full[65:0];
                    end
                    axis_reg  <= 1'b0;
                    step_reg  <= '0;
                    state_reg <= S_NUM;
                end
                S_NUM:
                begin
                    if (step_reg == 7'd2)
                    begin
                        num_reg   <= acc[98:0];
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                S_DIV:
                begin
                    if (step_reg != pcr_pkg::STEP_W'(pcr_pkg::DIV_STEPS))
                    begin
                        // One quotient bit per cycle
                        rem_reg  <= cs_ge ? cs_diff[65:0] : cs_a[65:0];
                        num_reg  <= {num_reg[97:0], cs_ge};
                        step_reg <= step_reg + 7'd1;
                    end
                    else if (!axis_reg)
                    begin
                        ptx_reg   <= coord_new;
                        axis_reg  <= 1'b1;
                        step_reg  <= '0;
                        state_reg <= S_NUM;
                    end
                    else
                    begin
                        // Move the center to the new point
                        cx_reg    <= ptx_reg;
                        cy_reg    <= coord_new;
                        count_reg <= count_reg + CNT_W'(1);
                        step_reg  <= '0;
                        state_reg <= S_CHK;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
